// File: src/isort_pkg.sv
`default_nettype none

package isort_pkg;

    localparam int KEY_W       = 32;
    localparam int DEPTH_DFLT  = 64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_DRD,
        ST_DLD,
        ST_DOUT
    } state_t;

endpackage

`default_nettype wire

// File: src/insertion_sorter.sv
`default_nettype none

// Stable insertion sorter for signed 32-bit keys.
//
// Input channel s_*: one key per transfer, s_tlast closes the set. Output
// channel m_*: the stored keys of the set in ascending order, m_tlast on the
// largest one, m_tuser set on every result when keys were dropped because
// the store already held DEPTH entries. Equal keys leave in arrival order.
//
// One comparator and a store with one write port and one registered read
// port do the work. A stored key steps down past each larger key below it,
// one read (ST_READ) and one compare and write (ST_CMP) per place, to the
// lowest entry at most; s_tready is low from its transfer until it is
// written. A dropped key leaves s_tready high unless it is the last. After
// the last key each result is read (ST_DRD), loaded (ST_DLD) and offered
// (ST_DOUT) until the receiver takes it; the result register holds its key
// until the transfer and no input is taken until the set is out.
//
// Reset (rst_n low) empties the store and clears the overflow flag; the
// store contents themselves are not cleared, only entries already written
// are ever read.
module insertion_sorter #(
    parameter int DEPTH = isort_pkg::DEPTH_DFLT
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [isort_pkg::KEY_W-1:0] s_tdata,   // [31:0] key
    input  wire logic                       s_tlast,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [isort_pkg::KEY_W-1:0]     m_tdata,   // [31:0] key_res
    output logic                            m_tlast,
    output logic                            m_tuser    // [0] overflow
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    isort_pkg::state_t state_reg, state_next;

    logic signed [isort_pkg::KEY_W-1:0] mem [DEPTH];
    logic signed [isort_pkg::KEY_W-1:0] rdata_reg;
    logic [AW-1:0]                      raddr;
    logic [AW-1:0]                      waddr;
    logic signed [isort_pkg::KEY_W-1:0] wdata;
    logic                               mem_we;

    logic signed [isort_pkg::KEY_W-1:0] key_reg, key_next;
    logic signed [isort_pkg::KEY_W-1:0] out_key_reg, out_key_next;
    logic                               last_reg, last_next;
    logic [AW-1:0]                      pos_reg, pos_next;
    logic [AW-1:0]                      idx_reg, idx_next;
    logic [CW-1:0]                      fill_reg, fill_next;
    logic                               drop_reg, drop_next;

    logic s_xfer;
    logic m_xfer;
    logic key_less;
    logic at_top;
    logic final_res;

    assign s_tready  = (state_reg == isort_pkg::ST_IDLE);
    assign s_xfer    = s_tvalid && s_tready;
    assign m_tvalid  = (state_reg == isort_pkg::ST_DOUT);
    assign m_xfer    = m_tvalid && m_tready;
    assign key_less  = key_reg < rdata_reg;
    assign at_top    = (pos_reg == '0);
    assign final_res = ((CW'(idx_reg) + CW'(1)) == fill_reg);

    assign m_tdata = out_key_reg;
    assign m_tlast = final_res;
    assign m_tuser = drop_reg;

    // store: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            isort_pkg::ST_IDLE:
            begin
                if (s_xfer)
                begin
                    if (fill_reg == FULL)
                    begin
                        state_next = s_tlast ? isort_pkg::ST_DRD : isort_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = isort_pkg::ST_READ;
                    end
                end
            end
            isort_pkg::ST_READ:
            begin
                if (at_top)
                begin
                    state_next = last_reg ? isort_pkg::ST_DRD : isort_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = isort_pkg::ST_CMP;
                end
            end
            isort_pkg::ST_CMP:
            begin
                if (key_less)
                begin
                    state_next = isort_pkg::ST_READ;
                end
                else
                begin
                    state_next = last_reg ? isort_pkg::ST_DRD : isort_pkg::ST_IDLE;
                end
            end
            isort_pkg::ST_DRD:
            begin
                state_next = isort_pkg::ST_DLD;
            end
            isort_pkg::ST_DLD:
            begin
                state_next = isort_pkg::ST_DOUT;
            end
            isort_pkg::ST_DOUT:
            begin
                if (m_xfer)
                begin
                    state_next = final_res ? isort_pkg::ST_IDLE : isort_pkg::ST_DRD;
                end
            end
            default:
            begin
                state_next = isort_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and store control
    always_comb
    begin
        key_next     = key_reg;
        last_next    = last_reg;
        pos_next     = pos_reg;
        idx_next     = idx_reg;
        fill_next    = fill_reg;
        drop_next    = drop_reg;
        out_key_next = out_key_reg;
        mem_we       = 1'b0;
        waddr        = pos_reg;
        wdata        = key_reg;
        raddr        = pos_reg - AW'(1);
        case (state_reg)
            isort_pkg::ST_IDLE:
            begin
                idx_next = '0;
                if (s_xfer)
                begin
                    key_next  = s_tdata;
                    last_next = s_tlast;
                    if (fill_reg == FULL)
                    begin
                        drop_next = 1'b1;
                    end
                    else
                    begin
                        pos_next = fill_reg[AW-1:0];
                    end
                end
            end
            isort_pkg::ST_READ:
            begin
                if (at_top)
                begin
                    mem_we    = 1'b1;
                    fill_next = fill_reg + CW'(1);
                end
            end
            isort_pkg::ST_CMP:
            begin
                mem_we = 1'b1;
                if (key_less)
                begin
                    // move the larger key up one place
                    wdata    = rdata_reg;
                    pos_next = pos_reg - AW'(1);
                end
                else
                begin
                    fill_next = fill_reg + CW'(1);
                end
            end
            isort_pkg::ST_DRD:
            begin
                raddr = idx_reg;
            end
            isort_pkg::ST_DLD:
            begin
                out_key_next = rdata_reg;
            end
            isort_pkg::ST_DOUT:
            begin
                if (m_xfer)
                begin
                    if (final_res)
                    begin
                        fill_next = '0;
                        drop_next = 1'b0;
                    end
                    else
                    begin
                        idx_next = idx_reg + AW'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= isort_pkg::ST_IDLE;
            fill_reg  <= '0;
            drop_reg  <= 1'b0;
            idx_reg   <= '0;
            pos_reg   <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            drop_reg  <= drop_next;
            idx_reg   <= idx_next;
            pos_reg   <= pos_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        out_key_reg <= out_key_next;
    end

endmodule

`default_nettype wire

// File: src/isort_checker.sv
`default_nettype none

module isort_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        s_tvalid,
    input wire logic                        s_tready,
    input wire logic [isort_pkg::KEY_W-1:0] s_tdata,
    input wire logic                        s_tlast,
    input wire logic                        m_tvalid,
    input wire logic                        m_tready,
    input wire logic [isort_pkg::KEY_W-1:0] m_tdata,
    input wire logic                        m_tlast,
    input wire logic                        m_tuser
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)
                                     && $stable(m_tlast) && $stable(m_tuser)))
        else $error("stalled result changed");

    // no input is taken while a set drains
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready during drain");

    // a key without last gives no result in the next cycle
    a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !s_tlast) |=> !m_tvalid)
        else $error("result without last key");

    // after the final result the block returns to taking keys
    a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> (!m_tvalid && s_tready))
        else $error("drain did not end after final result");

endmodule

bind insertion_sorter isort_checker u_isort_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire
